// ===== src/gps_nmea_ubx_frame_splitter_macros.svh =====
// ----------------------------------------------------------------------------
// GPS frame splitter assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GPS_NMEA_UBX_FRAME_SPLITTER_MACROS_SVH
`define GPS_NMEA_UBX_FRAME_SPLITTER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GNUFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gnufs assertion failed");
// next-cycle implication
`define GNUFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gnufs assertion failed");
`else
`define GNUFS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define GNUFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/gnufs_pkg.sv =====
// ----------------------------------------------------------------------------
// GPS frame splitter package
// Codes, byte constants and the per-beat result record.
// ----------------------------------------------------------------------------
package gnufs_pkg;

  // parser modes
  localparam logic [1:0] MODE_HUNT = 2'd0;
  localparam logic [1:0] MODE_NMEA = 2'd1;
  localparam logic [1:0] MODE_UBX  = 2'd2;

  // frame kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_NMEA = 2'd1;
  localparam logic [1:0] KIND_UBX  = 2'd2;

  // status codes
  localparam logic [2:0] ST_BUSY     = 3'd0;
  localparam logic [2:0] ST_OK       = 3'd1;
  localparam logic [2:0] ST_CSUM_BAD = 3'd2;
  localparam logic [2:0] ST_DISCARD  = 3'd3;
  localparam logic [2:0] ST_BAD_SYNC = 3'd4;
  localparam logic [2:0] ST_TOO_LONG = 3'd5;
  localparam logic [2:0] ST_OVERFLOW = 3'd6;

  // framing bytes
  localparam logic [7:0] NMEA_START = 8'h24;
  localparam logic [7:0] LINE_FEED  = 8'h0A;
  localparam logic [7:0] UBX_SYNC1  = 8'hB5;
  localparam logic [7:0] UBX_SYNC2  = 8'h62;

  // UBX header positions
  localparam logic [15:0] UBX_POS_SYNC2  = 16'd1;
  localparam logic [15:0] UBX_POS_CLASS  = 16'd2;
  localparam logic [15:0] UBX_POS_ID     = 16'd3;
  localparam logic [15:0] UBX_POS_LEN_LO = 16'd4;
  localparam logic [15:0] UBX_POS_LEN_HI = 16'd5;

  // header plus checksum bytes around the payload
  localparam logic [16:0] UBX_OVERHEAD = 17'd8;
  // checksum bytes at the tail
  localparam logic [16:0] UBX_TAIL     = 17'd2;

  localparam logic [15:0] MAX_FRAME_RESET = 16'd512;
  localparam logic [15:0] COUNT_SHOW_MAX  = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [1:0]  frame_kind;
    logic [15:0] byte_position;
    logic        frame_start;
    logic        frame_end;
    logic [2:0]  status;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] frame_length;
    logic [15:0] checksum_error_count;
  } result_t;

endpackage

// ===== src/gnufs_parser.sv =====
// ----------------------------------------------------------------------------
// GPS frame splitter parser
// Parse state, Fletcher sums and failure counter; classifies one byte per step.
// ----------------------------------------------------------------------------
module gnufs_parser #(
  parameter int ERROR_COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  input  logic [15:0]           max_frame_len,
  output gnufs_pkg::result_t    res
);
  import gnufs_pkg::*;

  localparam int CW = (ERROR_COUNT_BITS > 16) ? ERROR_COUNT_BITS : 16;

  logic [1:0]                  mode_r, mode_nxt;
  logic [15:0]                 idx_r, idx_nxt;
  logic [16:0]                 exp_len_r, exp_len_nxt;
  logic [7:0]                  sum_a_r, sum_a_nxt;
  logic [7:0]                  sum_b_r, sum_b_nxt;
  logic [7:0]                  class_r, class_nxt;
  logic [7:0]                  id_r, id_nxt;
  logic [7:0]                  len_lo_r, len_lo_nxt;
  logic                        first_ok_r, first_ok_nxt;
  logic [ERROR_COUNT_BITS-1:0] fail_r, fail_nxt;

  logic [7:0]  add_a, add_b;
  logic [16:0] pos_tail;
  logic [16:0] hdr_len;

  // Fletcher step and length arithmetic
  assign add_a     = sum_a_r + rx_byte;
  assign add_b     = sum_b_r + add_a;
  assign pos_tail  = {1'b0, idx_r} + UBX_TAIL;
  assign hdr_len   = {1'b0, rx_byte, len_lo_r} + UBX_OVERHEAD;

  // next state and result for the byte at hand
  always_comb begin
    logic [CW-1:0] fail_show;
    mode_nxt     = mode_r;
    idx_nxt      = idx_r;
    exp_len_nxt  = exp_len_r;
    sum_a_nxt    = sum_a_r;
    sum_b_nxt    = sum_b_r;
    class_nxt    = class_r;
    id_nxt       = id_r;
    len_lo_nxt   = len_lo_r;
    first_ok_nxt = first_ok_r;
    fail_nxt     = fail_r;
    res          = '0;
    res.byte_out = rx_byte;

    case (mode_r)
      MODE_NMEA: begin
        res.frame_kind    = KIND_NMEA;
        res.byte_position = idx_r;
        if (idx_r >= max_frame_len) begin
          res.frame_end = 1'b1;
          res.status    = ST_OVERFLOW;
          mode_nxt      = MODE_HUNT;
          idx_nxt       = '0;
        end else if (rx_byte == LINE_FEED) begin
          res.frame_end    = 1'b1;
          res.status       = ST_OK;
          res.frame_length = idx_r + 16'd1;
          mode_nxt         = MODE_HUNT;
          idx_nxt          = '0;
        end else begin
          idx_nxt = idx_r + 16'd1;
        end
      end

      MODE_UBX: begin
        res.frame_kind    = KIND_UBX;
        res.byte_position = idx_r;
        if (idx_r == UBX_POS_SYNC2) begin
          if (rx_byte != UBX_SYNC2) begin
            res.frame_end = 1'b1;
            res.status    = ST_BAD_SYNC;
            mode_nxt      = MODE_HUNT;
            idx_nxt       = '0;
          end else begin
            idx_nxt = idx_r + 16'd1;
          end
        end else if (idx_r == UBX_POS_CLASS || idx_r == UBX_POS_ID ||
                     idx_r == UBX_POS_LEN_LO) begin
          if (idx_r == UBX_POS_CLASS) class_nxt  = rx_byte;
          if (idx_r == UBX_POS_ID)    id_nxt     = rx_byte;
          if (idx_r == UBX_POS_LEN_LO) len_lo_nxt = rx_byte;
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          idx_nxt   = idx_r + 16'd1;
        end else if (idx_r == UBX_POS_LEN_HI) begin
          sum_a_nxt   = add_a;
          sum_b_nxt   = add_b;
          exp_len_nxt = hdr_len;
          if (hdr_len > {1'b0, max_frame_len}) begin
            res.frame_end = 1'b1;
            res.status    = ST_TOO_LONG;
            mode_nxt      = MODE_HUNT;
            idx_nxt       = '0;
          end else begin
            idx_nxt = idx_r + 16'd1;
          end
        end else if (pos_tail < exp_len_r) begin
          // payload
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          idx_nxt   = idx_r + 16'd1;
        end else if (pos_tail == exp_len_r) begin
          // first check byte
          first_ok_nxt = (rx_byte == sum_a_r);
          idx_nxt      = idx_r + 16'd1;
        end else begin
          // second check byte closes the frame
          res.frame_end    = 1'b1;
          res.frame_length = exp_len_r[15:0];
          if (first_ok_r && (rx_byte == sum_b_r)) begin
            res.status = ST_OK;
          end else begin
            res.status = ST_CSUM_BAD;
            if (fail_r != {ERROR_COUNT_BITS{1'b1}}) fail_nxt = fail_r + 1'b1;
          end
          mode_nxt = MODE_HUNT;
          idx_nxt  = '0;
        end
        res.msg_class = class_nxt;
        res.msg_id    = id_nxt;
      end

      default: begin
        // hunting, also for the unused mode code
        mode_nxt = MODE_HUNT;
        if (rx_byte == NMEA_START) begin
          res.frame_kind  = KIND_NMEA;
          res.frame_start = 1'b1;
          mode_nxt        = MODE_NMEA;
          idx_nxt         = 16'd1;
        end else if (rx_byte == UBX_SYNC1) begin
          res.frame_kind  = KIND_UBX;
          res.frame_start = 1'b1;
          mode_nxt        = MODE_UBX;
          idx_nxt         = 16'd1;
          sum_a_nxt       = '0;
          sum_b_nxt       = '0;
          class_nxt       = '0;
          id_nxt          = '0;
          len_lo_nxt      = '0;
          first_ok_nxt    = 1'b0;
          exp_len_nxt     = '0;
        end else begin
          res.status = ST_DISCARD;
          idx_nxt    = '0;
        end
      end
    endcase

    // failure count shown saturated to the port width
    fail_show = CW'(fail_nxt);
    res.checksum_error_count = (fail_show > CW'(COUNT_SHOW_MAX)) ? COUNT_SHOW_MAX
                                                                  : fail_show[15:0];
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_HUNT;
      idx_r      <= '0;
      exp_len_r  <= '0;
      sum_a_r    <= '0;
      sum_b_r    <= '0;
      class_r    <= '0;
      id_r       <= '0;
      len_lo_r   <= '0;
      first_ok_r <= 1'b0;
      fail_r     <= '0;
    end else if (step) begin
      mode_r     <= mode_nxt;
      idx_r      <= idx_nxt;
      exp_len_r  <= exp_len_nxt;
      sum_a_r    <= sum_a_nxt;
      sum_b_r    <= sum_b_nxt;
      class_r    <= class_nxt;
      id_r       <= id_nxt;
      len_lo_r   <= len_lo_nxt;
      first_ok_r <= first_ok_nxt;
      fail_r     <= fail_nxt;
    end
  end

endmodule

// ===== src/gps_nmea_ubx_frame_splitter.sv =====
// ----------------------------------------------------------------------------
// GPS NMEA/UBX frame splitter
// Tags every received byte with frame kind, position and status.
// An input beat passes the input register and the result register on its way
// to a result beat. Throughput: one byte per cycle while out_tready is not
// held low. Reset (rst_n low, synchronous) empties both registers, returns
// the parser to hunting, clears the failure count and loads max_frame_len 512.
// ----------------------------------------------------------------------------
`include "gps_nmea_ubx_frame_splitter_macros.svh"

module gps_nmea_ubx_frame_splitter #(
  parameter int ERROR_COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] rx_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,    // [7:0] byte_out, [23:8] byte_position,
                                    // [26:24] status, [34:27] msg_class,
                                    // [42:35] msg_id, [58:43] frame_length,
                                    // [74:59] checksum_error_count, rest zero
  output logic [2:0]  out_tuser,    // [1:0] frame_kind, [2] frame_start
  output logic        out_tlast,    // frame_end
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data   // max_frame_len
);
  import gnufs_pkg::*;

  logic        in_valid_r, in_valid_nxt;
  logic [7:0]  in_byte_r;
  logic        out_valid_r, out_valid_nxt;
  result_t     out_res_r;
  logic [15:0] max_len_r;
  logic        advance;
  result_t     res;

  // a byte moves on when the result register is free or being emptied
  assign advance      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready    = !in_valid_r || advance;
  assign in_valid_nxt = (in_tvalid && in_tready) ? 1'b1 :
                        advance                  ? 1'b0 : in_valid_r;
  assign out_valid_nxt = advance    ? 1'b1 :
                         out_tready ? 1'b0 : out_valid_r;

  gnufs_parser #(
    .ERROR_COUNT_BITS (ERROR_COUNT_BITS)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .rx_byte       (in_byte_r),
    .max_frame_len (max_len_r),
    .res           (res)
  );

  // handshake state and frame limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      max_len_r   <= MAX_FRAME_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) max_len_r <= cfg_wr_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) in_byte_r <= in_tdata;
    if (advance)                out_res_r <= res;
  end

  // output packing
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0,
                       out_res_r.checksum_error_count,
                       out_res_r.frame_length,
                       out_res_r.msg_id,
                       out_res_r.msg_class,
                       out_res_r.status,
                       out_res_r.byte_position,
                       out_res_r.byte_out};
  assign out_tuser  = {out_res_r.frame_start, out_res_r.frame_kind};
  assign out_tlast  = out_res_r.frame_end;

  // an opening byte never closes its frame
  `GNUFS_ASSERT_NOW(a_start_not_end, clk, rst_n,
    out_valid_r && out_res_r.frame_start, !out_res_r.frame_end && out_res_r.status == ST_BUSY)
  // length only reported on a closing beat
  `GNUFS_ASSERT_NOW(a_len_on_end, clk, rst_n,
    out_valid_r && !out_res_r.frame_end, out_res_r.frame_length == 16'd0)
  // unframed bytes are discarded at position zero
  `GNUFS_ASSERT_NOW(a_none_discard, clk, rst_n,
    out_valid_r && out_res_r.frame_kind == KIND_NONE,
    out_res_r.status == ST_DISCARD && out_res_r.byte_position == 16'd0)
  // a taken byte always lands in the result register
  `GNUFS_ASSERT_NEXT(a_advance_loads, clk, rst_n, advance, out_valid_r)

endmodule
